@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked outside reset
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

@@ src/tmr_pkg.sv @@
// ----------------------------------------------------------------------------
// tmr_pkg
// types and constants of the text mode pixel renderer
// ----------------------------------------------------------------------------
package tmr_pkg;

  localparam int COLUMNS          = 80;
  localparam int ROWS             = 25;
  localparam int MAX_GLYPH_HEIGHT = 16;
  localparam int GLYPH_WIDTH      = 8;
  localparam int CURSOR_ROWS      = 2;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int FONT_DEPTH = 256 * MAX_GLYPH_HEIGHT;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam int FONT_AW    = $clog2(FONT_DEPTH);

  localparam int HEIGHT_W  = 5;
  localparam int PERIOD_W  = 10;
  localparam int CFG_DW    = 10;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = 5'd8;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 10'd50;

  // pixel_y over glyph height, one quotient bit per step
  localparam int DIVIDEND_W = 9;
  localparam int DIVISOR_W  = 5;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CW     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ACT_WRITE_CELL = 3'd0,
    ACT_WRITE_FONT = 3'd1,
    ACT_SET_CURSOR = 3'd2,
    ACT_TICK       = 3'd3,
    ACT_RENDER     = 3'd4
  } action_t;

  typedef enum logic [0:0] {
    REG_GLYPH_HEIGHT = 1'b0,
    REG_BLINK_PERIOD = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] column;
    logic [4:0] row;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [3:0] glyph_row;
    logic [7:0] row_bits;
    logic [9:0] pixel_x;
    logic [8:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pixel_color;
    logic       in_range;
    logic       cursor_shown;
  } out_item_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_res_t;

endpackage

@@ src/tmr_if.sv @@
// ----------------------------------------------------------------------------
// tmr channel interfaces
// valid/ready channels for input items and rendered pixels
// ----------------------------------------------------------------------------
interface tmr_in_if import tmr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tmr_out_if import tmr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/tmr_div.sv @@
// ----------------------------------------------------------------------------
// tmr_div
// bit-serial restoring divider, pixel row over glyph height
// ----------------------------------------------------------------------------
module tmr_div import tmr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_res_t              res
);

  logic                  busy;
  logic                  done;
  logic [DIV_CW-1:0]     count;
  logic [DIVIDEND_W-1:0] num;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dq;
  logic [DIVISOR_W-1:0]  trial;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_next;

  // remainder stays below the divisor, which is at most sixteen
  always_comb begin
    trial    = {rem[DIVISOR_W-2:0], num[DIVIDEND_W-1]};
    ge       = (trial >= dq);
    rem_next = ge ? (trial - dq) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dq  <= divisor;
    end else if (busy) begin
      num <= {num[DIVIDEND_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign res.done      = done;
  assign res.quotient  = num;
  assign res.remainder = rem;

endmodule

@@ src/text_mode_pixel_renderer.sv @@
// ----------------------------------------------------------------------------
// text_mode_pixel_renderer
// text mode character generator with cell, font and cursor state
// ----------------------------------------------------------------------------
// After reset the block clears the font memory (the cell memory is cleared
// alongside) and takes no item during that time; register writes are taken
// throughout. Cell writes, font writes, cursor sets, ticks and unused actions
// are carried out as they are accepted. A render item goes from acceptance
// to the result register through the bit-serial division of pixel_y by the
// glyph height, then the cell memory read, font memory read and color pick;
// the color pick waits while the output register holds an untaken result. One
// item is in work at a time; a result waiting in the output register does not
// hold off non-render items.
module text_mode_pixel_renderer import tmr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  tmr_in_if.sink            in_ch,
  tmr_out_if.source         out_ch
);

`include "assert_macros.svh"

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_FONT  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [FONT_AW-1:0]  clear_addr;
  logic [HEIGHT_W-1:0] glyph_height;
  logic [PERIOD_W-1:0] blink_period;
  logic [6:0]          cursor_column;
  logic [4:0]          cursor_row;
  logic                cursor_on;
  logic [PERIOD_W-1:0] blink_count;
  logic [PERIOD_W-1:0] blink_inc;

  logic [15:0] cell_mem [CELL_COUNT];
  logic [7:0]  font_mem [FONT_DEPTH];
  logic        cell_we;
  logic [CELL_AW-1:0] cell_waddr;
  logic [15:0] cell_wdata;
  logic        font_we;
  logic [FONT_AW-1:0] font_waddr;
  logic [7:0]  font_wdata;
  logic        cell_re;
  logic [CELL_AW-1:0] cell_raddr;
  logic [15:0] cell_q;
  logic        font_re;
  logic [FONT_AW-1:0] font_raddr;
  logic [7:0]  font_q;

  logic        accept;
  in_item_t    item;
  logic [HEIGHT_W-1:0] eff_height;
  logic        item_inside;

  logic [HEIGHT_W-1:0] r_height;
  logic        r_inside;
  logic [6:0]  r_ccol;
  logic [2:0]  r_gx;
  logic [4:0]  r_crow;
  logic [3:0]  r_gy;

  div_res_t    div_res;
  logic        div_start;

  logic        out_valid;
  out_item_t   out_item;
  logic        out_load;
  logic        glyph_bit;
  logic        cursor_hit;
  logic [3:0]  color;

  assign item   = in_ch.payload;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);

  always_comb begin
    eff_height = glyph_height;
    if (glyph_height == '0) begin
      eff_height = HEIGHT_RESET;
    end else if (glyph_height > HEIGHT_W'(MAX_GLYPH_HEIGHT)) begin
      eff_height = HEIGHT_W'(MAX_GLYPH_HEIGHT);
    end
    item_inside = (item.pixel_x < 10'(COLUMNS * GLYPH_WIDTH)) &&
                  (10'(item.pixel_y) < 10'(ROWS) * 10'(eff_height));
  end

  assign div_start = accept && (item.action == ACT_RENDER);

  tmr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (item.pixel_y),
    .divisor  (eff_height),
    .res      (div_res)
  );

  // state sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == FONT_AW'(FONT_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (div_start) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_FONT;
        end
      end
      ST_FONT: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // memory write ports
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = clear_addr[CELL_AW-1:0];
    cell_wdata = '0;
    font_we    = 1'b0;
    font_waddr = clear_addr;
    font_wdata = '0;
    if (state == ST_CLEAR) begin
      cell_we = (clear_addr < FONT_AW'(CELL_COUNT));
      font_we = 1'b1;
    end else if (accept) begin
      case (item.action)
        ACT_WRITE_CELL: begin
          cell_we    = (item.column < 7'(COLUMNS)) && (item.row < 5'(ROWS));
          cell_waddr = CELL_AW'(item.row) * CELL_AW'(COLUMNS) + CELL_AW'(item.column);
          cell_wdata = {item.char_code, item.attribute};
        end
        ACT_WRITE_FONT: begin
          font_we    = 1'b1;
          font_waddr = {item.char_code, item.glyph_row};
          font_wdata = item.row_bits;
        end
        default: begin
          cell_we = 1'b0;
          font_we = 1'b0;
        end
      endcase
    end
  end

  // memory read ports
  always_comb begin
    cell_re    = (state == ST_DIV) && div_res.done;
    cell_raddr = '0;
    if (r_inside) begin
      cell_raddr = CELL_AW'(div_res.quotient[4:0]) * CELL_AW'(COLUMNS) +
                   CELL_AW'(r_ccol);
    end
    font_re    = (state == ST_FONT);
    font_raddr = {cell_q[15:8], r_gy};
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[font_waddr] <= font_wdata;
    end
    if (font_re) begin
      font_q <= font_mem[font_raddr];
    end
  end

  // render context
  always_ff @(posedge clk) begin
    if (div_start) begin
      r_height <= eff_height;
      r_inside <= item_inside;
      r_ccol   <= item.pixel_x[9:3];
      r_gx     <= item.pixel_x[2:0];
    end
    if (cell_re) begin
      r_crow <= div_res.quotient[4:0];
      r_gy   <= div_res.remainder[3:0];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_height <= HEIGHT_RESET;
      blink_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_GLYPH_HEIGHT: glyph_height <= cfg_data[HEIGHT_W-1:0];
        REG_BLINK_PERIOD: blink_period <= cfg_data[PERIOD_W-1:0];
        default:          glyph_height <= glyph_height;
      endcase
    end
  end

  // cursor and blink
  assign blink_inc = blink_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
      cursor_on     <= 1'b1;
      blink_count   <= '0;
    end else if (accept) begin
      case (item.action)
        ACT_SET_CURSOR: begin
          cursor_column <= item.column;
          cursor_row    <= item.row;
        end
        ACT_TICK: begin
          if (blink_inc >= blink_period) begin
            cursor_on   <= ~cursor_on;
            blink_count <= '0;
          end else begin
            blink_count <= blink_inc;
          end
        end
        default: blink_count <= blink_count;
      endcase
    end
  end

  // color pick
  always_comb begin
    glyph_bit  = font_q[3'(GLYPH_WIDTH - 1) - r_gx];
    cursor_hit = cursor_on && (cursor_column < 7'(COLUMNS)) &&
                 (cursor_row < 5'(ROWS)) && (r_ccol == cursor_column) &&
                 (r_crow == cursor_row) &&
                 (HEIGHT_W'(r_gy) + HEIGHT_W'(CURSOR_ROWS) >= r_height);
    color = '0;
    if (r_inside) begin
      color = (glyph_bit || cursor_hit) ? cell_q[3:0] : cell_q[7:4];
    end
  end

  assign out_load = (state == ST_OUT) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.pixel_color  <= color;
      out_item.in_range     <= r_inside;
      out_item.cursor_shown <= cursor_on;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  `ASSERT_CLK(a_reset_clears, clk, rst |=> (state == ST_CLEAR), "reset must start clearing")
  `ASSERT_CLK_RST(a_clear_once, clk, rst, (state != ST_CLEAR) |=> (state != ST_CLEAR), "clearing pass re-entered")
  `ASSERT_CLK_RST(a_div_done_state, clk, rst, div_res.done |-> (state == ST_DIV), "divider finished outside render")
  `ASSERT_CLK_RST(a_gy_range, clk, rst, ((state == ST_OUT) && r_inside) |-> (HEIGHT_W'(r_gy) < r_height), "glyph row beyond glyph height")

endmodule

@@ tb/tb_text_mode_pixel_renderer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_mode_pixel_renderer
// Drives cell, font, cursor, tick and render transactions into the block
// under random idling on both channels. A local model of the cell and font
// stores, cursor and blink state predicts every rendered pixel, and the
// monitor checks each output transaction field by field in order. The run
// goes through a directed phase and several random phases with different
// glyph heights and blink periods, including the edge settings.
// ----------------------------------------------------------------------------
module tb_text_mode_pixel_renderer;
  import tmr_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  reg_index_t        cfg_index = REG_GLYPH_HEIGHT;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  in_item_t          in_data = '0;
  logic              out_ready = 1'b0;

  tmr_in_if  in_ch ();
  tmr_out_if out_ch ();

  assign in_ch.valid   = in_valid;
  assign in_ch.payload = in_data;
  assign out_ch.ready  = out_ready;

  text_mode_pixel_renderer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // local copy of the block state
  logic [15:0]         screen [CELL_COUNT];
  logic [7:0]          font [FONT_DEPTH];
  logic [6:0]          cur_col;
  logic [4:0]          cur_row;
  logic                cur_on;
  logic [PERIOD_W-1:0] blink_cnt;
  logic [HEIGHT_W-1:0] height_cfg;
  logic [PERIOD_W-1:0] period_cfg;

  in_item_t  send_queue [$];
  out_item_t pending_pixels [$];
  int        errors = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        gen_cur_c = 0;
  int        gen_cur_r = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int eff_height(input int h);
    if (h == 0) return 8;
    if (h > MAX_GLYPH_HEIGHT) return MAX_GLYPH_HEIGHT;
    return h;
  endfunction

  function automatic out_item_t render_pixel(input in_item_t it);
    out_item_t   res;
    int          h, px, py, ccol, gx, crow, gy;
    logic [15:0] cell_word;
    logic [7:0]  bits;
    logic [3:0]  fg, bg;
    h  = eff_height(int'(height_cfg));
    px = int'(it.pixel_x);
    py = int'(it.pixel_y);
    res = '0;
    if (px < COLUMNS * GLYPH_WIDTH && py < ROWS * h) begin
      ccol = px / GLYPH_WIDTH;
      gx   = px % GLYPH_WIDTH;
      crow = py / h;
      gy   = py % h;
      cell_word = screen[crow * COLUMNS + ccol];
      fg   = cell_word[3:0];
      bg   = cell_word[7:4];
      bits = font[int'(cell_word[15:8]) * MAX_GLYPH_HEIGHT + gy];
      res.pixel_color = bits[7 - gx] ? fg : bg;
      if (cur_on && cur_col < COLUMNS && cur_row < ROWS && ccol == int'(cur_col) &&
          crow == int'(cur_row) && gy + CURSOR_ROWS >= h)
        res.pixel_color = fg;
      res.in_range = 1'b1;
    end
    res.cursor_shown = cur_on;
    return res;
  endfunction

  task automatic apply_item(input in_item_t it);
    case (it.action)
      ACT_WRITE_CELL: begin
        if (it.column < COLUMNS && it.row < ROWS)
          screen[int'(it.row) * COLUMNS + int'(it.column)] = {it.char_code, it.attribute};
      end
      ACT_WRITE_FONT: begin
        if (it.glyph_row < MAX_GLYPH_HEIGHT)
          font[int'(it.char_code) * MAX_GLYPH_HEIGHT + int'(it.glyph_row)] = it.row_bits;
      end
      ACT_SET_CURSOR: begin
        cur_col = it.column;
        cur_row = it.row;
      end
      ACT_TICK: begin
        blink_cnt = blink_cnt + 1'b1;
        if (blink_cnt >= period_cfg) begin
          cur_on    = ~cur_on;
          blink_cnt = '0;
        end
      end
      ACT_RENDER: pending_pixels.push_back(render_pixel(it));
      default: ;
    endcase
  endtask

  // output check first, then prediction, so one edge never races itself
  always @(posedge clk) begin
    if (rst) begin
      foreach (screen[i]) screen[i] = '0;
      foreach (font[i]) font[i] = '0;
      cur_col    = '0;
      cur_row    = '0;
      cur_on     = 1'b1;
      blink_cnt  = '0;
      height_cfg = HEIGHT_RESET;
      period_cfg = PERIOD_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pixels.size() == 0) begin
          report($sformatf("unexpected transaction %h", out_ch.payload));
        end else begin
          out_item_t want;
          want = pending_pixels.pop_front();
          if (out_ch.payload.pixel_color !== want.pixel_color)
            report($sformatf("pixel_color got %0d want %0d",
                             out_ch.payload.pixel_color, want.pixel_color));
          if (out_ch.payload.in_range !== want.in_range)
            report($sformatf("in_range got %0d want %0d",
                             out_ch.payload.in_range, want.in_range));
          if (out_ch.payload.cursor_shown !== want.cursor_shown)
            report($sformatf("cursor_shown got %0d want %0d",
                             out_ch.payload.cursor_shown, want.cursor_shown));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_GLYPH_HEIGHT) height_cfg = cfg_data[HEIGHT_W-1:0];
        else period_cfg = cfg_data[PERIOD_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) apply_item(in_ch.payload);
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_ch.ready) begin
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (send_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      gap_left <= $urandom_range(0, 3);
    end else begin
      in_valid <= 1'b1;
      in_data  <= send_queue.pop_front();
    end
  end

  // result sink stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_item_t make_item(input action_t a, input int col, input int row,
                                         input int chr, input int attr, input int grow,
                                         input int bits, input int px, input int py);
    in_item_t it;
    it           = '0;
    it.action    = a;
    it.column    = 7'(col);
    it.row       = 5'(row);
    it.char_code = 8'(chr);
    it.attribute = 8'(attr);
    it.glyph_row = 4'(grow);
    it.row_bits  = 8'(bits);
    it.pixel_x   = 10'(px);
    it.pixel_y   = 9'(py);
    return it;
  endfunction

  function automatic void pick_cell(output int c, output int r);
    c = $urandom_range(0, 3);
    r = $urandom_range(0, 2);
    if ($urandom_range(0, 1)) c = COLUMNS - 1 - c;
    if ($urandom_range(0, 1)) r = ROWS - 1 - r;
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 7) return 8'h40 + 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  function automatic in_item_t random_item(input int h);
    in_item_t    it;
    logic [63:0] raw;
    int          pick, c, r;
    raw  = {$urandom, $urandom};
    it   = in_item_t'(raw[$bits(in_item_t)-1:0]);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.action = ACT_RENDER;
      pick = $urandom_range(0, 99);
      if (pick < 20 && gen_cur_c < COLUMNS && gen_cur_r < ROWS) begin
        it.pixel_x = 10'(gen_cur_c * GLYPH_WIDTH + $urandom_range(0, GLYPH_WIDTH - 1));
        it.pixel_y = 9'(gen_cur_r * h + $urandom_range((h > 3) ? h - 3 : 0, h - 1));
      end else if (pick < 75) begin
        pick_cell(c, r);
        it.pixel_x = 10'(c * GLYPH_WIDTH + $urandom_range(0, GLYPH_WIDTH - 1));
        it.pixel_y = 9'(r * h + $urandom_range(0, h - 1));
      end else if (pick < 90) begin
        it.pixel_x = 10'($urandom_range(0, COLUMNS * GLYPH_WIDTH - 1));
        it.pixel_y = 9'($urandom_range(0, ROWS * h - 1));
      end
    end else if (pick < 65) begin
      it.action = ACT_WRITE_CELL;
      if ($urandom_range(0, 9) < 8) begin
        pick_cell(c, r);
        it.column    = 7'(c);
        it.row       = 5'(r);
        it.char_code = pick_char();
      end
    end else if (pick < 80) begin
      it.action    = ACT_WRITE_FONT;
      it.char_code = pick_char();
    end else if (pick < 87) begin
      it.action = ACT_SET_CURSOR;
      if ($urandom_range(0, 9) < 8) begin
        pick_cell(c, r);
        it.column = 7'(c);
        it.row    = 5'(r);
      end
      gen_cur_c = it.column;
      gen_cur_r = it.row;
    end else if (pick < 97) begin
      it.action = ACT_TICK;
    end else begin
      it.action = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  task automatic set_config(input int h, input int p);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GLYPH_HEIGHT;
    cfg_data  <= CFG_DW'(h);
    @(posedge clk);
    cfg_index <= REG_BLINK_PERIOD;
    cfg_data  <= CFG_DW'(p);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // sender holds off until every pixel is back and the block has settled
  task automatic wait_idle();
    do @(negedge clk);
    while (send_queue.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    int ph, h, p;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    gap_pct   = 20;
    stall_pct = 20;
    set_config(8, 1);
    @(negedge clk);
    send_queue.push_back(make_item(ACT_WRITE_FONT, 0, 0, 8'h41, 0, 0, 8'h80, 0, 0));
    send_queue.push_back(make_item(ACT_WRITE_FONT, 0, 0, 8'h41, 0, 7, 8'h01, 0, 0));
    send_queue.push_back(make_item(ACT_WRITE_FONT, 0, 0, 8'hFF, 0, 15, 8'hFF, 0, 0));
    send_queue.push_back(make_item(ACT_WRITE_CELL, 0, 0, 8'h41, 8'hA5, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_WRITE_CELL, 79, 24, 8'hFF, 8'hF0, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_WRITE_CELL, 80, 0, 8'h41, 8'h12, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_WRITE_CELL, 0, 25, 8'h41, 8'h12, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_WRITE_CELL, 127, 31, 8'h41, 8'h12, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 1, 0));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 7, 7));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 3, 7));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 639, 199));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 640, 0));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 0, 200));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 1023, 511));
    send_queue.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 3, 7));
    send_queue.push_back(make_item(ACT_SET_CURSOR, 79, 24, 0, 0, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 639, 199));
    send_queue.push_back(make_item(ACT_SET_CURSOR, 127, 31, 0, 0, 0, 0, 0, 0));
    send_queue.push_back(make_item(ACT_RENDER, 0, 0, 0, 0, 0, 0, 639, 199));
    send_queue.push_back(in_item_t'({3'd5, 59'h0}));
    send_queue.push_back(in_item_t'({3'd7, 59'h0}));
    gen_cur_c = 127;
    gen_cur_r = 31;
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin h = 16; p = 1023; end
        1: begin h = 1;  p = 0;    end
        2: begin h = 0;  p = 2;    end
        3: begin h = 31; p = 5;    end
        4: begin h = 12; p = 3;    end
        7: begin h = 8;  p = 50;   end
        default: begin
          h = $urandom_range(1, 16);
          p = $urandom_range(1, 40);
        end
      endcase
      @(negedge clk);
      gap_pct   = (ph == 7) ? 0 : (ph == 3) ? 40 : 20;
      stall_pct = gap_pct;
      set_config(h, p);
      @(negedge clk);
      repeat (150) send_queue.push_back(random_item(eff_height(h)));
      wait_idle();
    end

    repeat (30) @(negedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("PASS text_mode_pixel_renderer");
    end else begin
      $display("FAIL text_mode_pixel_renderer");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL text_mode_pixel_renderer");
    $finish;
  end

endmodule
